/* rtl/pstm_pkg.sv */
// ----------------------------------------------------------------------------
// Peak station throughput monitor package
// Shared widths, operation and phase codes, and the structs that travel
// between the modules of the monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package pstm_pkg;

   localparam int OP_W    = 3;
   localparam int SLOT_W  = 5;
   localparam int BYTE_W  = 32;
   localparam int TICK_W  = 16;
   localparam int COEFF_W = 18;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int PROD_W  = BYTE_W + COEFF_W;

   // Register index, taken from the word address of the register port.
   localparam logic REG_TICK_PERIOD = 1'b0;
   localparam logic REG_RATE_COEFF  = 1'b1;

   localparam logic KIND_ROUND_DUE   = 1'b0;
   localparam logic KIND_THROUGHPUT  = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_START      = 3'd0,
      OP_STOP       = 3'd1,
      OP_CONNECT    = 3'd2,
      OP_DISCONNECT = 3'd3,
      OP_TICK       = 3'd4,
      OP_SAMPLE     = 3'd5,
      OP_ROUND_END  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      PH_STOPPED = 2'd0,
      PH_ARMED   = 2'd1,
      PH_PRIMING = 2'd2,
      PH_MEASURE = 2'd3
   } phase_type;

   // One accepted item, held in the input register.
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] rx;
      logic [BYTE_W-1:0] tx;
   } item_type;

   // Current register values and the tick period write event.
   typedef struct packed {
      logic [TICK_W-1:0]  tick_period;
      logic [COEFF_W-1:0] rate_coeff;
      logic               period_wr;
      logic [TICK_W-1:0]  period_new;
   } cfg_type;

   // Write of the stored counters of one slot.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] rx;
      logic [BYTE_W-1:0] tx;
   } store_wr_type;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic              priming;
      logic [BYTE_W-1:0] peak;
      logic [BYTE_W-1:0] bps;
   } result_type;

endpackage

`default_nettype wire

/* rtl/pstm_csr.sv */
// ----------------------------------------------------------------------------
// Peak station throughput monitor register port
// Holds the tick period and rate coefficient and signals period writes.
// ----------------------------------------------------------------------------
`default_nettype none

module pstm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [pstm_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [pstm_pkg::CSR_DW-1:0]    pwdata,
   output logic      [pstm_pkg::CSR_DW-1:0]    prdata,
   output logic                                pready,
   output pstm_pkg::cfg_type                   cfg
);

   logic [pstm_pkg::TICK_W-1:0]  tick_period_ff, tick_period_in;
   logic [pstm_pkg::COEFF_W-1:0] rate_coeff_ff, rate_coeff_in;
   logic                         wr_en;
   logic                         reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;

   always_comb begin
      tick_period_in = tick_period_ff;
      rate_coeff_in  = rate_coeff_ff;
      if (wr_en) begin
         case (reg_sel)
            pstm_pkg::REG_TICK_PERIOD: tick_period_in = pwdata[pstm_pkg::TICK_W-1:0];
            pstm_pkg::REG_RATE_COEFF:  rate_coeff_in  = pwdata[pstm_pkg::COEFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= pstm_pkg::TICK_W'(1);
         rate_coeff_ff  <= '0;
      end else begin
         tick_period_ff <= tick_period_in;
         rate_coeff_ff  <= rate_coeff_in;
      end
   end

   always_comb begin
      case (reg_sel)
         pstm_pkg::REG_TICK_PERIOD: prdata = pstm_pkg::CSR_DW'(tick_period_ff);
         pstm_pkg::REG_RATE_COEFF:  prdata = pstm_pkg::CSR_DW'(rate_coeff_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.tick_period = tick_period_ff;
   assign cfg.rate_coeff  = rate_coeff_ff;
   assign cfg.period_wr   = wr_en && (reg_sel == pstm_pkg::REG_TICK_PERIOD);
   assign cfg.period_new  = pwdata[pstm_pkg::TICK_W-1:0];

endmodule

`default_nettype wire

/* rtl/pstm_count_store.sv */
// ----------------------------------------------------------------------------
// Peak station throughput monitor counter store
// Per-slot memory of the last rx and tx byte counts, with registered read
// and forwarding of a write that lands in the same cycle as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module pstm_count_store #(
   parameter int SLOTS = 32
) (
   input  wire logic                              clock,
   input  wire logic [pstm_pkg::SLOT_W-1:0]       rd_slot,
   input  wire pstm_pkg::store_wr_type            wr,
   output logic      [pstm_pkg::BYTE_W-1:0]       last_rx,
   output logic      [pstm_pkg::BYTE_W-1:0]       last_tx
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [pstm_pkg::BYTE_W-1:0] rx_mem [SLOTS];
   logic [pstm_pkg::BYTE_W-1:0] tx_mem [SLOTS];
   logic [pstm_pkg::BYTE_W-1:0] rd_rx_ff;
   logic [pstm_pkg::BYTE_W-1:0] rd_tx_ff;
   logic [AW-1:0]               rd_addr;
   logic [AW-1:0]               wr_addr;
   logic                        fwd;

   assign rd_addr = AW'(rd_slot);
   assign wr_addr = AW'(wr.slot);
   // A write in this cycle would not yet be seen by the memory read.
   assign fwd     = wr.en && (wr.slot == rd_slot);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rx_mem[wr_addr] <= wr.rx;
         tx_mem[wr_addr] <= wr.tx;
      end
   end

   always_ff @(posedge clock) begin
      if (fwd) begin
         rd_rx_ff <= wr.rx;
         rd_tx_ff <= wr.tx;
      end else begin
         rd_rx_ff <= rx_mem[rd_addr];
         rd_tx_ff <= tx_mem[rd_addr];
      end
   end

   assign last_rx = rd_rx_ff;
   assign last_tx = rd_tx_ff;

endmodule

`default_nettype wire

/* rtl/pstm_engine.sv */
// ----------------------------------------------------------------------------
// Peak station throughput monitor engine
// Phase and tick control, slot tables, running peak and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pstm_engine #(
   parameter int SLOTS     = 32,
   parameter int FRAC_BITS = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pstm_pkg::item_type            item,
   input  wire pstm_pkg::cfg_type             cfg,
   input  wire logic [pstm_pkg::BYTE_W-1:0]   last_rx,
   input  wire logic [pstm_pkg::BYTE_W-1:0]   last_tx,
   output pstm_pkg::store_wr_type             wr,
   output pstm_pkg::result_type               result
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   pstm_pkg::phase_type         phase_ff, phase_in;
   logic [pstm_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [pstm_pkg::BYTE_W-1:0] peak_ff, peak_in;
   logic [SLOTS-1:0]            valid_ff, valid_in;
   logic [SLOTS-1:0]            in_use_ff, in_use_in;
   pstm_pkg::result_type        result_ff, result_in;

   logic [AW-1:0]               addr;
   logic                        slot_ok;
   logic [pstm_pkg::TICK_W-1:0] tick_next;
   logic [pstm_pkg::BYTE_W-1:0] drx;
   logic [pstm_pkg::BYTE_W-1:0] dtx;
   logic [pstm_pkg::PROD_W-1:0] prod;
   logic [pstm_pkg::PROD_W-1:0] prod_shr;

   assign addr      = AW'(item.slot);
   assign slot_ok   = int'(item.slot) < SLOTS;
   assign tick_next = tick_ff + pstm_pkg::TICK_W'(1);
   assign drx       = item.rx - last_rx;
   assign dtx       = item.tx - last_tx;
   assign prod      = pstm_pkg::PROD_W'(peak_ff) * pstm_pkg::PROD_W'(cfg.rate_coeff);
   assign prod_shr  = prod >> FRAC_BITS;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      peak_in   = peak_ff;
      valid_in  = valid_ff;
      in_use_in = in_use_ff;
      result_in = '0;
      wr.en     = 1'b0;
      wr.slot   = item.slot;
      wr.rx     = item.rx;
      wr.tx     = item.tx;

      if (cfg.period_wr) begin
         // A new period restarts a running measurement.
         if (phase_ff != pstm_pkg::PH_STOPPED) begin
            phase_in = pstm_pkg::PH_ARMED;
            tick_in  = cfg.period_new - pstm_pkg::TICK_W'(1);
            peak_in  = '0;
         end
      end else if (item.valid) begin
         case (item.op)
            pstm_pkg::OP_START: begin
               if (phase_ff == pstm_pkg::PH_STOPPED) begin
                  phase_in = pstm_pkg::PH_ARMED;
                  tick_in  = cfg.tick_period - pstm_pkg::TICK_W'(1);
                  peak_in  = '0;
               end
            end
            pstm_pkg::OP_STOP: begin
               phase_in = pstm_pkg::PH_STOPPED;
            end
            pstm_pkg::OP_CONNECT: begin
               if (slot_ok) begin
                  in_use_in[addr] = 1'b1;
                  valid_in[addr]  = 1'b0;
               end
            end
            pstm_pkg::OP_DISCONNECT: begin
               if (slot_ok) begin
                  in_use_in[addr] = 1'b0;
                  valid_in[addr]  = 1'b0;
               end
            end
            pstm_pkg::OP_TICK: begin
               if (phase_ff != pstm_pkg::PH_STOPPED) begin
                  if (tick_next == cfg.tick_period) begin
                     tick_in          = '0;
                     result_in.valid  = 1'b1;
                     result_in.kind   = pstm_pkg::KIND_ROUND_DUE;
                     if (phase_ff == pstm_pkg::PH_ARMED) begin
                        phase_in          = pstm_pkg::PH_PRIMING;
                        result_in.priming = 1'b1;
                     end else begin
                        phase_in = pstm_pkg::PH_MEASURE;
                        peak_in  = '0;
                     end
                  end else begin
                     tick_in = tick_next;
                  end
               end
            end
            pstm_pkg::OP_SAMPLE: begin
               if (slot_ok && in_use_ff[addr]) begin
                  if (phase_ff == pstm_pkg::PH_PRIMING) begin
                     wr.en          = 1'b1;
                     valid_in[addr] = 1'b1;
                  end else if (phase_ff == pstm_pkg::PH_MEASURE) begin
                     wr.en = 1'b1;
                     if (!valid_ff[addr]) begin
                        valid_in[addr] = 1'b1;
                     end else begin
                        if (drx > peak_in) peak_in = drx;
                        if (dtx > peak_in) peak_in = dtx;
                     end
                  end
               end
            end
            pstm_pkg::OP_ROUND_END: begin
               if (phase_ff == pstm_pkg::PH_MEASURE) begin
                  result_in.valid = 1'b1;
                  result_in.kind  = pstm_pkg::KIND_THROUGHPUT;
                  result_in.peak  = peak_ff;
                  result_in.bps   = prod_shr[pstm_pkg::BYTE_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pstm_pkg::PH_STOPPED;
         tick_ff   <= '0;
         peak_ff   <= '0;
         valid_ff  <= '0;
         in_use_ff <= '0;
         result_ff.valid <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         peak_ff   <= peak_in;
         valid_ff  <= valid_in;
         in_use_ff <= in_use_in;
         result_ff.valid <= result_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff.kind    <= result_in.kind;
      result_ff.priming <= result_in.priming;
      result_ff.peak    <= result_in.peak;
      result_ff.bps     <= result_in.bps;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* rtl/peak_station_throughput_monitor_core.sv */
// ----------------------------------------------------------------------------
// Peak station throughput monitor core
// Tracks station slots, paces sampling rounds and reports peak throughput.
// ----------------------------------------------------------------------------
// Usage: the host issues one command beat when start is high and busy is low.
// busy never rises, so a new command is taken on every clock cycle. Commands
// are start, stop, connect, disconnect, tick, sample and round end, with the
// slot and the cumulative rx and tx byte counts in the same beat.
// A tick that completes the programmed period produces a round-due beat on
// the rsp_ ports; a round end during a measuring round produces a throughput
// beat with the peak byte delta and its conversion to bytes per second.
// Each result beat is shown for one cycle with rsp_valid high, starting at
// the clock edge after the one that took the command: the taking edge loads
// the input register and the counter memory read, the next updates the state
// and the result register. The receiver cannot stall; every beat must be
// taken when shown. The tick period and rate coefficient live on the
// APB-style register port and must be written by the user only while no
// command is in flight; the block does not enforce this. Reset clears the
// phase, tick count, running peak and slot flags at once; the stored counter
// memory is left unset, since a slot only becomes valid when it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_station_throughput_monitor_core #(
   parameter int SLOTS     = 32,
   parameter int FRAC_BITS = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Command channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [pstm_pkg::OP_W-1:0]      req_op,
   input  wire logic [pstm_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic [pstm_pkg::BYTE_W-1:0]    req_rx_bytes,
   input  wire logic [pstm_pkg::BYTE_W-1:0]    req_tx_bytes,
   // Result channel
   output logic                                rsp_valid,
   output logic                                rsp_result_kind,
   output logic                                rsp_priming_round,
   output logic      [pstm_pkg::BYTE_W-1:0]    rsp_peak_bytes,
   output logic      [pstm_pkg::BYTE_W-1:0]    rsp_bytes_per_second,
   // Register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [pstm_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [pstm_pkg::CSR_DW-1:0]    pwdata,
   output logic      [pstm_pkg::CSR_DW-1:0]    prdata,
   output logic                                pready
);

   pstm_pkg::item_type     item_ff, item_in;
   pstm_pkg::cfg_type      cfg;
   pstm_pkg::store_wr_type wr;
   pstm_pkg::result_type   result;
   logic [pstm_pkg::BYTE_W-1:0] last_rx;
   logic [pstm_pkg::BYTE_W-1:0] last_tx;

   // Every command is taken in the cycle it is offered.
   assign busy = 1'b0;

   always_comb begin
      item_in.valid = start && !busy;
      item_in.op    = pstm_pkg::op_type'(req_op);
      item_in.slot  = req_slot;
      item_in.rx    = req_rx_bytes;
      item_in.tx    = req_tx_bytes;
   end

   // Input register: the valid flag is control, the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff.op   <= item_in.op;
      item_ff.slot <= item_in.slot;
      item_ff.rx   <= item_in.rx;
      item_ff.tx   <= item_in.tx;
   end

   pstm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The memory read is issued with the incoming beat so that its registered
   // data lines up with the input register.
   pstm_count_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .rd_slot (req_slot),
      .wr      (wr),
      .last_rx (last_rx),
      .last_tx (last_tx)
   );

   pstm_engine #(
      .SLOTS     (SLOTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .item    (item_ff),
      .cfg     (cfg),
      .last_rx (last_rx),
      .last_tx (last_tx),
      .wr      (wr),
      .result  (result)
   );

   assign rsp_valid            = result.valid;
   assign rsp_result_kind      = result.kind;
   assign rsp_priming_round    = result.priming;
   assign rsp_peak_bytes       = result.peak;
   assign rsp_bytes_per_second = result.bps;

endmodule

`default_nettype wire
